@@ rtl/jbse_pkg.sv @@
// ----------------------------------------------------------------------------
// jbse_pkg
// Types and codes shared by the jtag bit shift engine modules.
// ----------------------------------------------------------------------------
package jbse_pkg;

   localparam int unsigned OpWidth      = 2;
   localparam int unsigned PayloadWidth = 32;
   localparam int unsigned CountWidth   = 6;
   localparam int unsigned ModeWidth    = 2;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned PosWidth     = 3;

   // longest data shift in bits
   localparam logic [CountWidth-1:0] ShiftMaxBits = CountWidth'(8);

   localparam logic [ByteWidth-1:0] AllZeros = 8'h00;
   localparam logic [ByteWidth-1:0] AllOnes  = 8'hFF;

   typedef enum logic [OpWidth-1:0] {
      OP_SHIFT = 2'd0,
      OP_WALK  = 2'd1,
      OP_FREE  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      JOB_IDLE  = 2'd0,
      JOB_SHIFT = 2'd1,
      JOB_WALK  = 2'd2,
      JOB_FREE  = 2'd3
   } job_type;

   localparam logic [ModeWidth-1:0] SEND_PAYLOAD = 2'd0;
   localparam logic [ModeWidth-1:0] SEND_ZEROS   = 2'd1;
   localparam logic [ModeWidth-1:0] SEND_ONES    = 2'd2;

   typedef struct packed {
      op_type                  operation;
      logic [PayloadWidth-1:0] payload;
      logic [CountWidth-1:0]   bit_count;
      logic [ModeWidth-1:0]    send_mode;
      logic                    capture;
      logic                    exit_on_last;
      logic                    tdo_level;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic                 busy_res;
      logic                 tck_pulse;
      logic                 tdi_level;
      logic                 tms_level;
      logic                 tdo_valid;
      logic [ByteWidth-1:0] tdo_byte;
   } rsp_type;

endpackage

@@ rtl/jtag_bit_shift_engine_core.sv @@
// ----------------------------------------------------------------------------
// jtag_bit_shift_engine_core
// JTAG master shift engine: command and tick transactions in, pin levels out.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while the output is not stalled. A
// transaction is registered on entry, the job state (shift word, clock
// counter, capture byte, held TDI/TMS levels) is updated from that register,
// and the result lands in an output register; a stalled output holds the
// job state. Rate is set by the update loop of the job state; the output
// register lets the next transaction enter while a result waits to be taken.
module jtag_bit_shift_engine_core #(
   parameter int unsigned TMS_PATTERN_BITS = 32,
   parameter int unsigned COUNT_BITS       = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [jbse_pkg::OpWidth-1:0]         req_operation,
   input  logic [jbse_pkg::PayloadWidth-1:0]    req_payload,
   input  logic [jbse_pkg::CountWidth-1:0]      req_bit_count,
   input  logic [jbse_pkg::ModeWidth-1:0]       req_send_mode,
   input  logic                                 req_capture,
   input  logic                                 req_exit_on_last,
   input  logic                                 req_tdo_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_tck_pulse,
   output logic                                 rsp_tdi_level,
   output logic                                 rsp_tms_level,
   output logic                                 rsp_tdo_valid,
   output logic [jbse_pkg::ByteWidth-1:0]       rsp_tdo_byte
);
   import jbse_pkg::*;

   logic    in_valid_ff;
   req_type in_req_ff, in_req_in;
   logic    out_valid_ff;
   rsp_type out_rsp_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    fire;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_req_in.operation    = op_type'(req_operation);
      in_req_in.payload      = req_payload;
      in_req_in.bit_count    = req_bit_count;
      in_req_in.send_mode    = req_send_mode;
      in_req_in.capture      = req_capture;
      in_req_in.exit_on_last = req_exit_on_last;
      in_req_in.tdo_level    = req_tdo_level;
   end

   jbse_engine #(
      .TMS_PATTERN_BITS (TMS_PATTERN_BITS),
      .COUNT_BITS       (COUNT_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_req_ff),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= in_req_in;
      end
      if (fire) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_accepted  = out_rsp_ff.accepted;
   assign rsp_busy_res  = out_rsp_ff.busy_res;
   assign rsp_tck_pulse = out_rsp_ff.tck_pulse;
   assign rsp_tdi_level = out_rsp_ff.tdi_level;
   assign rsp_tms_level = out_rsp_ff.tms_level;
   assign rsp_tdo_valid = out_rsp_ff.tdo_valid;
   assign rsp_tdo_byte  = out_rsp_ff.tdo_byte;

endmodule

@@ rtl/jbse_engine.sv @@
// ----------------------------------------------------------------------------
// jbse_engine
// Job state of the shift engine: loads commands and advances one bit per tick.
// ----------------------------------------------------------------------------
module jbse_engine #(
   parameter int unsigned TMS_PATTERN_BITS = 32,
   parameter int unsigned COUNT_BITS       = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  jbse_pkg::req_type req,
   output jbse_pkg::rsp_type rsp
);
   import jbse_pkg::*;

   localparam int unsigned SW = TMS_PATTERN_BITS;
   localparam int unsigned CW = COUNT_BITS;

   logic [SW-1:0]        shift_word_ff,   shift_word_in;
   logic [CW-1:0]        clocks_left_ff,  clocks_left_in;
   job_type              job_kind_ff,     job_kind_in;
   logic [PosWidth-1:0]  bit_position_ff, bit_position_in;
   logic [ByteWidth-1:0] tdo_gather_ff,   tdo_gather_in;
   logic                 tdi_hold_ff,     tdi_hold_in;
   logic                 tms_hold_ff,     tms_hold_in;
   logic                 exit_flag_ff,    exit_flag_in;
   logic                 capture_flag_ff, capture_flag_in;

   logic [SW+PayloadWidth-1:0] payload_sw_ext;
   logic [CW+PayloadWidth-1:0] payload_cw_ext;
   logic [CW-1:0]              count_ext;
   logic [CW-1:0]              free_count;
   logic [CW-1:0]              walk_count;
   logic [CW-1:0]              shift_count;
   logic [ByteWidth-1:0]       tdi_byte;
   logic                       idle;
   logic                       last_bit;

   assign payload_sw_ext = {{SW{1'b0}}, req.payload};
   assign payload_cw_ext = {{CW{1'b0}}, req.payload};
   assign count_ext      = {{(CW-CountWidth){1'b0}}, req.bit_count};
   assign free_count     = payload_cw_ext[CW-1:0];
   assign idle           = (clocks_left_ff == '0);
   assign last_bit       = (clocks_left_ff == CW'(1));

   // saturate the shift and walk lengths
   assign shift_count = (req.bit_count > ShiftMaxBits) ? CW'(ShiftMaxBits) : count_ext;
   assign walk_count  = (count_ext > CW'(TMS_PATTERN_BITS)) ? CW'(TMS_PATTERN_BITS)
                                                            : count_ext;

   always_comb begin
      case (req.send_mode) inside
         SEND_PAYLOAD: tdi_byte = req.payload[ByteWidth-1:0];
         SEND_ZEROS:   tdi_byte = AllZeros;
         default:      tdi_byte = AllOnes;
      endcase
   end

   always_comb begin
      shift_word_in   = shift_word_ff;
      clocks_left_in  = clocks_left_ff;
      job_kind_in     = job_kind_ff;
      bit_position_in = bit_position_ff;
      tdo_gather_in   = tdo_gather_ff;
      tdi_hold_in     = tdi_hold_ff;
      tms_hold_in     = tms_hold_ff;
      exit_flag_in    = exit_flag_ff;
      capture_flag_in = capture_flag_ff;
      rsp             = '0;

      if (req.operation != OP_TICK) begin
         if (idle) begin
            rsp.accepted = 1'b1;
            unique case (req.operation)
               OP_SHIFT: begin
                  if (req.bit_count != '0) begin
                     shift_word_in   = {{(SW-ByteWidth){1'b0}}, tdi_byte};
                     clocks_left_in  = shift_count;
                     job_kind_in     = JOB_SHIFT;
                     bit_position_in = '0;
                     tdo_gather_in   = '0;
                     capture_flag_in = req.capture;
                     exit_flag_in    = req.exit_on_last;
                  end
               end
               OP_WALK: begin
                  if (req.bit_count != '0) begin
                     shift_word_in  = payload_sw_ext[SW-1:0];
                     clocks_left_in = walk_count;
                     job_kind_in    = JOB_WALK;
                  end
               end
               OP_FREE: begin
                  if (free_count != '0) begin
                     clocks_left_in = free_count;
                     job_kind_in    = JOB_FREE;
                  end
               end
               default: ;
            endcase
         end
      end else if (!idle) begin
         rsp.tck_pulse = 1'b1;
         if (job_kind_ff == JOB_SHIFT) begin
            tdi_hold_in   = shift_word_ff[0];
            shift_word_in = shift_word_ff >> 1;
            if (last_bit && exit_flag_ff) begin
               tms_hold_in = 1'b1;
            end
            if (capture_flag_ff) begin
               tdo_gather_in = tdo_gather_ff
                             | (ByteWidth'(req.tdo_level) << bit_position_ff);
            end
            bit_position_in = bit_position_ff + PosWidth'(1);
            if (last_bit && capture_flag_ff) begin
               rsp.tdo_valid = 1'b1;
               rsp.tdo_byte  = tdo_gather_in;
            end
         end else if (job_kind_ff == JOB_WALK) begin
            tms_hold_in   = shift_word_ff[0];
            shift_word_in = shift_word_ff >> 1;
         end
         clocks_left_in = clocks_left_ff - CW'(1);
         if (last_bit) begin
            job_kind_in = JOB_IDLE;
         end
      end

      rsp.busy_res  = (clocks_left_in != '0);
      rsp.tdi_level = tdi_hold_in;
      rsp.tms_level = tms_hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff   <= '0;
         clocks_left_ff  <= '0;
         job_kind_ff     <= JOB_IDLE;
         bit_position_ff <= '0;
         tdo_gather_ff   <= '0;
         tdi_hold_ff     <= 1'b0;
         tms_hold_ff     <= 1'b0;
         exit_flag_ff    <= 1'b0;
         capture_flag_ff <= 1'b0;
      end else if (fire) begin
         shift_word_ff   <= shift_word_in;
         clocks_left_ff  <= clocks_left_in;
         job_kind_ff     <= job_kind_in;
         bit_position_ff <= bit_position_in;
         tdo_gather_ff   <= tdo_gather_in;
         tdi_hold_ff     <= tdi_hold_in;
         tms_hold_ff     <= tms_hold_in;
         exit_flag_ff    <= exit_flag_in;
         capture_flag_ff <= capture_flag_in;
      end
   end

endmodule
